>>> rtl/s20sx_pkg.sv
`timescale 1ns / 1ps

package s20sx_pkg;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    localparam int ROUND_COUNT_DEF = 20;
    localparam int FIFO_DEPTH_DEF  = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0     = 3'd0,
        CFG_KEY_1     = 3'd1,
        CFG_KEY_2     = 3'd2,
        CFG_KEY_3     = 3'd3,
        CFG_NONCE     = 3'd4,
        CFG_START_CTR = 3'd5
    } cfg_idx_t;

    typedef logic [15:0][31:0] blk_t;

    typedef struct packed {
        logic [63:0] key_0;
        logic [63:0] key_1;
        logic [63:0] key_2;
        logic [63:0] key_3;
        logic [63:0] nonce;
    } key_cfg_t;

    // One word handed from the front to the back.
    typedef struct packed {
        logic [63:0] data_word;
        logic        need_block;
        logic [31:0] block_ctr;
        logic [31:0] next_ctr;
    } job_t;

    typedef struct packed {
        logic [31:0] block_counter;
        logic [2:0]  word_position;
    } front_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_FINAL,
        BK_EMIT
    } bk_state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int c);
        return (v << c) | (v >> (32 - c));
    endfunction

    // Returns {d, c, b, a} after one quarter round.
    function automatic logic [3:0][31:0] quarter(input logic [31:0] a, input logic [31:0] b,
                                                 input logic [31:0] c, input logic [31:0] d);
        logic [31:0] nb;
        logic [31:0] nc;
        logic [31:0] nd;
        logic [31:0] na;
        nb = b ^ rotl32(a + d, 7);
        nc = c ^ rotl32(nb + a, 9);
        nd = d ^ rotl32(nc + nb, 13);
        na = a ^ rotl32(nd + nc, 18);
        return {nd, nc, nb, na};
    endfunction

    function automatic blk_t column_round(input blk_t s);
        blk_t            r;
        logic [3:0][31:0] q0;
        logic [3:0][31:0] q1;
        logic [3:0][31:0] q2;
        logic [3:0][31:0] q3;
        q0 = quarter(s[0], s[4], s[8], s[12]);
        q1 = quarter(s[5], s[9], s[13], s[1]);
        q2 = quarter(s[10], s[14], s[2], s[6]);
        q3 = quarter(s[15], s[3], s[7], s[11]);
        r[0]  = q0[0]; r[4]  = q0[1]; r[8]  = q0[2]; r[12] = q0[3];
        r[5]  = q1[0]; r[9]  = q1[1]; r[13] = q1[2]; r[1]  = q1[3];
        r[10] = q2[0]; r[14] = q2[1]; r[2]  = q2[2]; r[6]  = q2[3];
        r[15] = q3[0]; r[3]  = q3[1]; r[7]  = q3[2]; r[11] = q3[3];
        return r;
    endfunction

    function automatic blk_t row_round(input blk_t s);
        blk_t            r;
        logic [3:0][31:0] q0;
        logic [3:0][31:0] q1;
        logic [3:0][31:0] q2;
        logic [3:0][31:0] q3;
        q0 = quarter(s[0], s[1], s[2], s[3]);
        q1 = quarter(s[5], s[6], s[7], s[4]);
        q2 = quarter(s[10], s[11], s[8], s[9]);
        q3 = quarter(s[15], s[12], s[13], s[14]);
        r[0]  = q0[0]; r[1]  = q0[1]; r[2]  = q0[2]; r[3]  = q0[3];
        r[5]  = q1[0]; r[6]  = q1[1]; r[7]  = q1[2]; r[4]  = q1[3];
        r[10] = q2[0]; r[11] = q2[1]; r[8]  = q2[2]; r[9]  = q2[3];
        r[15] = q3[0]; r[12] = q3[1]; r[13] = q3[2]; r[14] = q3[3];
        return r;
    endfunction

    function automatic blk_t init_block(input key_cfg_t k, input logic [31:0] ctr);
        blk_t s;
        s[0]  = SIGMA_0;
        s[1]  = k.key_0[31:0];
        s[2]  = k.key_0[63:32];
        s[3]  = k.key_1[31:0];
        s[4]  = k.key_1[63:32];
        s[5]  = SIGMA_1;
        s[6]  = k.nonce[31:0];
        s[7]  = k.nonce[63:32];
        s[8]  = ctr;
        s[9]  = 32'd0;
        s[10] = SIGMA_2;
        s[11] = k.key_2[31:0];
        s[12] = k.key_2[63:32];
        s[13] = k.key_3[31:0];
        s[14] = k.key_3[63:32];
        s[15] = SIGMA_3;
        return s;
    endfunction

endpackage

>>> rtl/s20sx_ifs.sv
`timescale 1ns / 1ps

interface s20sx_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic        start_req;
    logic        end_of_call;

    modport source (output valid, output data_word, output start_req, output end_of_call,
                    input ready);
    modport sink (input valid, input data_word, input start_req, input end_of_call,
                  output ready);
endinterface

interface s20sx_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_word;
    logic [31:0] next_counter;

    modport source (output valid, output out_word, output next_counter, input ready);
    modport sink (input valid, input out_word, input next_counter, output ready);
endinterface

>>> rtl/s20sx_front.sv
`timescale 1ns / 1ps

module s20sx_front
    import s20sx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    s20sx_in_if.sink    in_ch,
    input  logic [31:0] start_counter,
    input  logic        push_ready,
    output logic        push_valid,
    output job_t        push_job,
    output front_stat_t stat
);

    logic [31:0] block_counter_reg;
    logic [31:0] block_counter_next;
    logic [2:0]  word_position_reg;
    logic [2:0]  word_position_next;
    logic [31:0] ctr_cur;
    logic [2:0]  pos_cur;
    logic        need_block;
    logic        accept;

    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid;
    assign accept      = in_ch.valid && push_ready;

    always_comb
    begin
        ctr_cur            = in_ch.start_req ? start_counter : block_counter_reg;
        pos_cur            = in_ch.start_req ? 3'd0 : word_position_reg;
        need_block         = (pos_cur == 3'd0);
        block_counter_next = need_block ? ctr_cur + 32'd1 : ctr_cur;
        word_position_next = in_ch.end_of_call ? 3'd0 : pos_cur + 3'd1;

        push_job.data_word  = in_ch.data_word;
        push_job.need_block = need_block;
        push_job.block_ctr  = ctr_cur;
        push_job.next_ctr   = block_counter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_counter_reg <= 32'd0;
            word_position_reg <= 3'd0;
        end
        else if (accept)
        begin
            block_counter_reg <= block_counter_next;
            word_position_reg <= word_position_next;
        end
    end

    assign stat.block_counter = block_counter_reg;
    assign stat.word_position = word_position_reg;

endmodule

>>> rtl/s20sx_fifo.sv
`timescale 1ns / 1ps

module s20sx_fifo
    import s20sx_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_valid,
    output logic                       push_ready,
    input  job_t                       push_job,
    output logic                       pop_valid,
    input  logic                       pop_ready,
    output job_t                       pop_job,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> rtl/s20sx_back.sv
`timescale 1ns / 1ps

module s20sx_back
    import s20sx_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  key_cfg_t  key_cfg,
    input  logic      pop_valid,
    input  job_t      pop_job,
    output logic      pop_ready,
    s20sx_out_if.source out_ch,
    output bk_state_t state
);

    // An odd round count still runs whole double rounds.
    localparam int NUM_ROUNDS = 2 * ((ROUND_COUNT + 1) / 2);
    localparam int RC_W       = $clog2(NUM_ROUNDS);
    localparam logic [RC_W-1:0] LAST_ROUND = RC_W'(NUM_ROUNDS - 1);

    bk_state_t        state_reg;
    bk_state_t        state_next;
    logic [RC_W-1:0]  round_cnt_reg;
    logic [RC_W-1:0]  round_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    blk_t             work_reg;
    logic [7:0][63:0] ks_reg;
    job_t             job_reg;
    logic [63:0]      out_word_reg;
    logic [31:0]      out_ctr_reg;

    logic             slot_free;
    logic             load;
    logic             emit;
    logic [63:0]      emit_data;
    logic [31:0]      emit_ctr;
    blk_t             init_cur;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign init_cur  = init_block(key_cfg, job_reg.block_ctr);

    always_comb
    begin
        state_next     = state_reg;
        round_cnt_next = round_cnt_reg;
        case (state_reg)
            BK_IDLE:
            begin
                round_cnt_next = '0;
                if (pop_valid && pop_job.need_block)
                    state_next = BK_ROUND;
            end
            BK_ROUND:
            begin
                round_cnt_next = round_cnt_reg + RC_W'(1);
                if (round_cnt_reg == LAST_ROUND)
                    state_next = BK_FINAL;
            end
            BK_FINAL:
                state_next = BK_EMIT;
            BK_EMIT:
            begin
                if (slot_free)
                    state_next = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop_ready = 1'b0;
        load      = 1'b0;
        emit      = 1'b0;
        emit_data = job_reg.data_word;
        emit_ctr  = job_reg.next_ctr;
        case (state_reg)
            BK_IDLE:
            begin
                emit_data = pop_job.data_word;
                emit_ctr  = pop_job.next_ctr;
                load      = pop_valid && pop_job.need_block;
                emit      = pop_valid && !pop_job.need_block && slot_free;
                pop_ready = load || emit;
            end
            BK_EMIT:
                emit = slot_free;
            default:
            begin
            end
        endcase
        out_valid_next = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            round_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_cnt_reg <= round_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The keystream store is a shift line: the word for the next data word
    // always sits in the lowest slot.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_reg <= init_block(key_cfg, pop_job.block_ctr);
            job_reg  <= pop_job;
        end
        else if (state_reg == BK_ROUND)
            work_reg <= round_cnt_reg[0] ? row_round(work_reg) : column_round(work_reg);

        if (state_reg == BK_FINAL)
        begin
            for (int i = 0; i < 16; i++)
                ks_reg[i/2][32*(i%2) +: 32] <= work_reg[i] + init_cur[i];
        end
        else if (emit)
            ks_reg <= {64'd0, ks_reg[7:1]};

        if (emit)
        begin
            out_word_reg <= emit_data ^ ks_reg[0];
            out_ctr_reg  <= emit_ctr;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_word     = out_word_reg;
    assign out_ch.next_counter = out_ctr_reg;
    assign state               = state_reg;

endmodule

>>> rtl/salsa20_stream_xor_unit.sv
`timescale 1ns / 1ps

// Salsa20 stream XOR unit: each 64-bit word is XORed with the next 64 bits of
// keystream, and the result carries the counter of the next block. The first
// word of a block waits while the block is loaded, run through ROUND_COUNT
// rounds rounded up to even, given its final add and sent to the output; the
// other seven words of the block use the stored keystream and need no new
// block. The round core does one column or row round per cycle. A queue, two
// entries deep by default, lets input words be taken while a block is being
// computed, and an output register lets the next block be computed while a
// result waits to be taken. The user must write key, nonce and start counter
// through the configuration port only while the unit is idle; the unit
// itself does not enforce this.
module salsa20_stream_xor_unit
    import s20sx_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF,
    parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    s20sx_in_if.sink              in_ch,
    s20sx_out_if.source           out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    key_cfg_t    key_cfg_reg;
    logic [31:0] start_ctr_reg;

    logic        push_valid;
    logic        push_ready;
    job_t        push_job;
    logic        pop_valid;
    logic        pop_ready;
    job_t        pop_job;
    logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count;
    front_stat_t front_stat;
    bk_state_t   bk_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cfg_reg   <= '0;
            start_ctr_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_0:     key_cfg_reg.key_0 <= cfg_data;
                CFG_KEY_1:     key_cfg_reg.key_1 <= cfg_data;
                CFG_KEY_2:     key_cfg_reg.key_2 <= cfg_data;
                CFG_KEY_3:     key_cfg_reg.key_3 <= cfg_data;
                CFG_NONCE:     key_cfg_reg.nonce <= cfg_data;
                CFG_START_CTR: start_ctr_reg     <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    s20sx_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .start_counter (start_ctr_reg),
        .push_ready    (push_ready),
        .push_valid    (push_valid),
        .push_job      (push_job),
        .stat          (front_stat)
    );

    s20sx_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .count      (fifo_count)
    );

    s20sx_back #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_cfg   (key_cfg_reg),
        .pop_valid (pop_valid),
        .pop_job   (pop_job),
        .pop_ready (pop_ready),
        .out_ch    (out_ch),
        .state     (bk_state)
    );

    // A start word always opens a block, so the counter moves one past the
    // start value.
    a_start_ctr: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.start_req
        |=> front_stat.block_counter == $past(start_ctr_reg) + 32'd1)
        else $error("block counter not reloaded on start word");

    a_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.end_of_call
        |=> front_stat.word_position == 3'd0)
        else $error("end of call did not restart the block");

    // No word may leave the queue while a block is being computed.
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (bk_state == BK_ROUND || bk_state == BK_FINAL) |-> !pop_ready)
        else $error("queue popped during block computation");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count == ($bits(fifo_count))'(FIFO_DEPTH) |-> !in_ch.ready)
        else $error("input taken while queue is full");

endmodule
